@@ design/sas_pkg.sv @@
// ----------------------------------------------------------------------------
// sas_pkg: shared types and constants for the signed angle about axis block
// Holds component formats, pipeline depths, the CORDIC arctangent table and
// the structs that pass partial results between pipeline sections.
// ----------------------------------------------------------------------------
package sas_pkg;

  // component width, Q1.14 at 16 bits
  localparam int CompW       = 16;
  localparam int SqrtStages  = 32;
  localparam int DivStages   = 31;
  localparam int CordicIters = 16;
  localparam int AngleMax    = 12868;

  // pi in Q.30 for the left half plane start
  localparam logic signed [34:0] PiQ30 = 35'sd3373259426;

  typedef logic signed [CompW-1:0] comp_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
  } vec_t;

  // front end result: |c|^2, n2.n1, |n2.c| and flags
  typedef struct packed {
    logic [63:0]        mag2;
    logic signed [33:0] dot_x;
    logic [47:0]        yabs;
    logic               yneg;
    logic               degen;
  } front_t;

  // after the square root
  typedef struct packed {
    logic [31:0]        mag;
    logic signed [33:0] dot_x;
    logic [47:0]        yabs;
    logic               yneg;
    logic               degen;
  } sqrt_t;

  // after the divider
  typedef struct packed {
    logic [30:0]        yquot;
    logic               yneg;
    logic signed [33:0] dot_x;
    logic               degen;
  } div_t;

  // atan(2^-i) in Q.30
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:       v = 32'h3243F6A8;
      1:       v = 32'h1DAC6705;
      2:       v = 32'h0FADBAFC;
      3:       v = 32'h07F56EA6;
      4:       v = 32'h03FEAB76;
      5:       v = 32'h01FFD55B;
      6:       v = 32'h00FFFAAA;
      7:       v = 32'h007FFF55;
      8:       v = 32'h003FFFEA;
      9:       v = 32'h001FFFFD;
      10:      v = 32'h000FFFFF;
      11:      v = 32'h0007FFFF;
      12:      v = 32'h0003FFFF;
      13:      v = 32'h0001FFFF;
      14:      v = 32'h0000FFFF;
      15:      v = 32'h00007FFF;
      16:      v = 32'h00003FFF;
      17:      v = 32'h00001FFF;
      18:      v = 32'h00000FFF;
      19:      v = 32'h000007FF;
      20:      v = 32'h000003FF;
      21:      v = 32'h000001FF;
      22:      v = 32'h000000FF;
      23:      v = 32'h0000007F;
      24:      v = 32'h0000003F;
      25:      v = 32'h0000001F;
      26:      v = 32'h0000000F;
      27:      v = 32'h00000008;
      28:      v = 32'h00000004;
      29:      v = 32'h00000002;
      30:      v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

@@ design/signed_angle_about_axis.sv @@
// ----------------------------------------------------------------------------
// signed_angle_about_axis: signed angle between two normals about an axis
// Computes atan2(n2 . (c/|c|), n2 . n1) with c = axis x n1, in Q3.12.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one transfer per item, in_tdata carries nine signed
//   Q1.14 components: first_x/y/z, second_x/y/z, axis_x/y/z, lowest bits first.
//   Output channel out_*: one transfer per item, out_tdata[14:0] is the angle
//   in signed Q3.12 radians, out_tuser is the degenerate flag (axis parallel
//   to the first normal, angle then zero).
//   The pipeline is made of products and sums, 32 square root stages, 31
//   divider stages, 2 setup, 16 CORDIC iterations and 1 output stage. One
//   item enters per cycle unless the receiver stalls; the square root and
//   divider each resolve one bit per stage, which sets the depth.
//   Reset clears all valid bits; the pipeline is then empty and ready.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_tready drops; nothing is lost or repeated. Bubbles in flight are
//   kept as they are.
// ----------------------------------------------------------------------------
module signed_angle_about_axis (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, axis_x, axis_y, axis_z
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // angle, zero pad
  output logic [15:0]  out_tdata,
  // degenerate
  output logic         out_tuser
);
  import sas_pkg::*;

  logic   en;
  vec_t   first_v, second_v, axis_v;
  logic   front_valid, sqrt_valid, div_valid;
  front_t front_data;
  sqrt_t  sqrt_data;
  div_t   div_data;
  logic [14:0] angle;
  logic   degenerate;

  // pipeline advances unless a result is waiting
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  // unpack the input transfer
  assign first_v.x  = in_tdata[15:0];
  assign first_v.y  = in_tdata[31:16];
  assign first_v.z  = in_tdata[47:32];
  assign second_v.x = in_tdata[63:48];
  assign second_v.y = in_tdata[79:64];
  assign second_v.z = in_tdata[95:80];
  assign axis_v.x   = in_tdata[111:96];
  assign axis_v.y   = in_tdata[127:112];
  assign axis_v.z   = in_tdata[143:128];

  sas_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .first_v  (first_v),
    .second_v (second_v),
    .axis_v   (axis_v),
    .out_valid(front_valid),
    .out_data (front_data)
  );

  sas_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (front_valid),
    .in_data  (front_data),
    .out_valid(sqrt_valid),
    .out_data (sqrt_data)
  );

  sas_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (sqrt_valid),
    .in_data  (sqrt_data),
    .out_valid(div_valid),
    .out_data (div_data)
  );

  sas_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_valid),
    .in_data   (div_data),
    .out_valid (out_tvalid),
    .angle     (angle),
    .degenerate(degenerate)
  );

  assign out_tdata = {1'b0, angle};
  assign out_tuser = degenerate;

  // degenerate results carry a zero angle
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[14:0] == 15'd0)
    else $error("degenerate result with nonzero angle");

  // angle stays within plus or minus pi
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[14:0]) <= 15'sd12868) &&
                   ($signed(out_tdata[14:0]) >= -15'sd12868))
    else $error("angle out of range");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule

@@ design/sas_front.sv @@
// ----------------------------------------------------------------------------
// sas_front: cross product, squared magnitude and dot products
// Four register stages: products, cross and n2.n1 sums, squares and n2*c
// products, final sums with sign split of n2.c.
// ----------------------------------------------------------------------------
module sas_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  sas_pkg::vec_t  first_v,
  input  sas_pkg::vec_t  second_v,
  input  sas_pkg::vec_t  axis_v,
  output logic           out_valid,
  output sas_pkg::front_t out_data
);
  import sas_pkg::*;

  logic [3:0] v_r;

  logic signed [31:0] cp_r [6];
  logic signed [31:0] dp_r [3];
  vec_t               n2_s1_r, n2_s2_r;
  logic signed [32:0] c_r [3];
  logic signed [33:0] dotx_s2_r, dotx_s3_r;
  logic [63:0]        sq_r [3];
  logic signed [49:0] ny_r [3];
  front_t             res_r;

  logic signed [50:0] ysum;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  // stage 1: all 16x16 products
  always_ff @(posedge clk) begin
    if (en) begin
      cp_r[0] <= 32'(axis_v.y * first_v.z);
      cp_r[1] <= 32'(axis_v.z * first_v.y);
      cp_r[2] <= 32'(axis_v.z * first_v.x);
      cp_r[3] <= 32'(axis_v.x * first_v.z);
      cp_r[4] <= 32'(axis_v.x * first_v.y);
      cp_r[5] <= 32'(axis_v.y * first_v.x);
      dp_r[0] <= 32'(second_v.x * first_v.x);
      dp_r[1] <= 32'(second_v.y * first_v.y);
      dp_r[2] <= 32'(second_v.z * first_v.z);
      n2_s1_r <= second_v;
    end
  end

  // stage 2: cross product and n2.n1
  always_ff @(posedge clk) begin
    if (en) begin
      c_r[0]    <= 33'(cp_r[0]) - 33'(cp_r[1]);
      c_r[1]    <= 33'(cp_r[2]) - 33'(cp_r[3]);
      c_r[2]    <= 33'(cp_r[4]) - 33'(cp_r[5]);
      dotx_s2_r <= 34'(dp_r[0]) + 34'(dp_r[1]) + 34'(dp_r[2]);
      n2_s2_r   <= n2_s1_r;
    end
  end

  // stage 3: squares of c and n2 times c
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0]   <= 64'(c_r[0] * c_r[0]);
      sq_r[1]   <= 64'(c_r[1] * c_r[1]);
      sq_r[2]   <= 64'(c_r[2] * c_r[2]);
      ny_r[0]   <= 50'(n2_s2_r.x * c_r[0]);
      ny_r[1]   <= 50'(n2_s2_r.y * c_r[1]);
      ny_r[2]   <= 50'(n2_s2_r.z * c_r[2]);
      dotx_s3_r <= dotx_s2_r;
    end
  end

  // stage 4: sums, sign and magnitude of n2.c
  assign ysum = 51'(ny_r[0]) + 51'(ny_r[1]) + 51'(ny_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.mag2  <= sq_r[0] + sq_r[1] + sq_r[2];
      res_r.dot_x <= dotx_s3_r;
      res_r.yneg  <= ysum[50];
      res_r.yabs  <= ysum[50] ? 48'(-ysum) : 48'(ysum);
      res_r.degen <= (sq_r[0] + sq_r[1] + sq_r[2]) == 64'd0;
    end
  end

  assign out_valid = v_r[3];
  assign out_data  = res_r;

endmodule

@@ design/sas_sqrt.sv @@
// ----------------------------------------------------------------------------
// sas_sqrt: pipelined integer square root of |c|^2
// One result bit per stage, digit by digit on pairs of radicand bits.
// ----------------------------------------------------------------------------
module sas_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  sas_pkg::front_t in_data,
  output logic            out_valid,
  output sas_pkg::sqrt_t  out_data
);
  import sas_pkg::*;

  logic [SqrtStages-1:0] v_r;
  logic [31:0]           root_r [SqrtStages];
  logic [34:0]           rem_r  [SqrtStages];
  front_t                side_r [SqrtStages];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[SqrtStages-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < SqrtStages; k++) begin : g_stage
    logic [31:0] root_in;
    logic [34:0] rem_in;
    front_t      side_in;
    logic [34:0] rem_sh;
    logic [34:0] trial;

    if (k == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = '0;
      assign side_in = in_data;
    end else begin : g_next
      assign root_in = root_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign side_in = side_r[k-1];
    end

    // bring down the next bit pair and try root*4+1
    assign rem_sh = {rem_in[32:0], side_in.mag2[63-2*k -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_in;
        if (rem_sh >= trial) begin
          rem_r[k]  <= rem_sh - trial;
          root_r[k] <= {root_in[30:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_sh;
          root_r[k] <= {root_in[30:0], 1'b0};
        end
      end
    end
  end

  assign out_valid      = v_r[SqrtStages-1];
  assign out_data.mag   = root_r[SqrtStages-1];
  assign out_data.dot_x = side_r[SqrtStages-1].dot_x;
  assign out_data.yabs  = side_r[SqrtStages-1].yabs;
  assign out_data.yneg  = side_r[SqrtStages-1].yneg;
  assign out_data.degen = side_r[SqrtStages-1].degen;

endmodule

@@ design/sas_div.sv @@
// ----------------------------------------------------------------------------
// sas_div: pipelined restoring divider for |n2.c| * 2^14 / |c|
// One quotient bit per stage; the quotient is bounded below 2^31.
// ----------------------------------------------------------------------------
module sas_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  sas_pkg::sqrt_t in_data,
  output logic           out_valid,
  output sas_pkg::div_t  out_data
);
  import sas_pkg::*;

  logic [DivStages-1:0] v_r;
  logic [31:0]          rem_r  [DivStages];
  logic [30:0]          q_r    [DivStages];
  sqrt_t                side_r [DivStages];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DivStages-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic [31:0] rem_in;
    logic [30:0] q_in;
    sqrt_t       side_in;
    logic [61:0] dvd;
    logic [32:0] trial;

    if (k == 0) begin : g_first
      logic [61:0] dvd0;
      assign dvd0    = {in_data.yabs, 14'd0};
      assign rem_in  = {1'b0, dvd0[61:31]};
      assign q_in    = '0;
      assign side_in = in_data;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign q_in    = q_r[k-1];
      assign side_in = side_r[k-1];
    end

    // shift in the next dividend bit and compare against |c|
    assign dvd   = {side_in.yabs, 14'd0};
    assign trial = {rem_in, dvd[30-k]};

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_in;
        if (trial >= {1'b0, side_in.mag}) begin
          rem_r[k]    <= 32'(trial - {1'b0, side_in.mag});
          q_r[k]      <= q_in | (31'd1 << (30 - k));
        end else begin
          rem_r[k]    <= trial[31:0];
          q_r[k]      <= q_in;
        end
      end
    end
  end

  assign out_valid      = v_r[DivStages-1];
  assign out_data.yquot = q_r[DivStages-1];
  assign out_data.yneg  = side_r[DivStages-1].yneg;
  assign out_data.dot_x = side_r[DivStages-1].dot_x;
  assign out_data.degen = side_r[DivStages-1].degen;

endmodule

@@ design/sas_cordic.sv @@
// ----------------------------------------------------------------------------
// sas_cordic: vectoring CORDIC giving atan2(y, x) in Q3.12 radians
// Sign stage, half plane fold, one stage per iteration, round and clamp.
// ----------------------------------------------------------------------------
module sas_cordic (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  sas_pkg::div_t in_data,
  output logic          out_valid,
  output logic [14:0]   angle,
  output logic          degenerate
);
  import sas_pkg::*;

  // valid bits: sign, fold, iterations, output
  logic [CordicIters+2:0] v_r;

  logic signed [31:0] ys_r;
  logic signed [33:0] xs_r;
  logic               dg_s_r;

  logic signed [35:0] x_r [CordicIters+1];
  logic signed [35:0] y_r [CordicIters+1];
  logic signed [34:0] z_r [CordicIters+1];
  logic               zero_r [CordicIters+1];
  logic               dg_r   [CordicIters+1];

  logic [14:0] angle_r;
  logic        degen_r;

  logic signed [35:0] zr_sum;
  logic signed [16:0] zr_q12;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[CordicIters+1:0], in_valid};
    end
  end

  // apply the sign to the quotient
  always_ff @(posedge clk) begin
    if (en) begin
      ys_r   <= in_data.yneg ? -$signed({1'b0, in_data.yquot})
                             : $signed({1'b0, in_data.yquot});
      xs_r   <= in_data.dot_x;
      dg_s_r <= in_data.degen;
    end
  end

  // fold the left half plane and start at plus or minus pi
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (xs_r == 34'sd0) && (ys_r == 32'sd0);
      dg_r[0]   <= dg_s_r;
      if (xs_r < 0) begin
        x_r[0] <= -36'(xs_r);
        y_r[0] <= -36'(ys_r);
        z_r[0] <= (ys_r >= 0) ? PiQ30 : -PiQ30;
      end else begin
        x_r[0] <= 36'(xs_r);
        y_r[0] <= 36'(ys_r);
        z_r[0] <= '0;
      end
    end
  end

  // rotation stages
  for (genvar i = 0; i < CordicIters; i++) begin : g_iter
    logic signed [35:0] xsh, ysh;
    logic signed [34:0] step;

    assign xsh  = x_r[i] >>> i;
    assign ysh  = y_r[i] >>> i;
    assign step = 35'(atan_q30(i));

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        dg_r[i+1]   <= dg_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + ysh;
          y_r[i+1] <= y_r[i] - xsh;
          z_r[i+1] <= z_r[i] + step;
        end else begin
          x_r[i+1] <= x_r[i] - ysh;
          y_r[i+1] <= y_r[i] + xsh;
          z_r[i+1] <= z_r[i] - step;
        end
      end
    end
  end

  // round half up to Q.12 and clamp
  assign zr_sum = 36'(z_r[CordicIters]) + 36'sd131072;
  assign zr_q12 = 17'(zr_sum >>> 18);

  always_ff @(posedge clk) begin
    if (en) begin
      degen_r <= dg_r[CordicIters];
      if (dg_r[CordicIters] || zero_r[CordicIters]) begin
        angle_r <= '0;
      end else if (zr_q12 > 17'(AngleMax)) begin
        angle_r <= 15'(AngleMax);
      end else if (zr_q12 < -17'(AngleMax)) begin
        angle_r <= 15'(-AngleMax);
      end else begin
        angle_r <= zr_q12[14:0];
      end
    end
  end

  assign out_valid  = v_r[CordicIters+2];
  assign angle      = angle_r;
  assign degenerate = degen_r;

endmodule
